### rtl/core/brs_pkg.sv
package brs_pkg;

    // splitmix64 finalizer
    localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;
    localparam int          MIX_SH1  = 30;
    localparam int          MIX_SH2  = 27;
    localparam int          MIX_SH3  = 31;

    // mt19937-64 seeding and state
    localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
    localparam int          LCG_SH    = 62;
    localparam int          MT_N      = 312;
    localparam int          MT_M      = 156;
    localparam int          IDXW      = 9;
    localparam logic [63:0] MT_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] MT_UPPER  = 64'hFFFFFFFF80000000;
    localparam logic [63:0] MT_LOWER  = 64'h000000007FFFFFFF;
    localparam logic [63:0] TMP_B     = 64'h5555555555555555;
    localparam logic [63:0] TMP_C     = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TMP_D     = 64'hFFF7EEE000000000;

    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_DEPTH  = 2'd1;
    localparam logic [1:0] REG_FROZEN = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_BIN    = 3'd1,
        ST_FROZEN     = 3'd2,
        ST_NOT_FROZEN = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SD_CLEAR,
        OP_SD_LOADBIN,
        OP_SD_LOADSEED,
        OP_MUL1,
        OP_MUL2,
        OP_MULWAIT,
        OP_FIN,
        OP_SD_WR0,
        OP_LCG,
        OP_SD_WR,
        OP_SD_NEXT,
        OP_CHECK,
        OP_DRAW,
        OP_LIMWAIT,
        OP_GRD,
        OP_GUSE,
        OP_JSTART,
        OP_JWAIT,
        OP_JUSE,
        OP_RG0,
        OP_RG1,
        OP_RGR,
        OP_RGW
    } t_op;

    typedef struct packed {
        logic capture;
        logic res_load;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic seed_wr;
        logic mul_done;
        logic div_done;
        logic need_draw;
        logic n_le1;
        logic tw_full;
        logic u_ok;
        logic widx_last;
        logic bin_last;
    } t_dp_stat;

endpackage

### rtl/core/brs_mul.sv
// low 64 bits of a 64x64 product from one 32x32 multiplier
module brs_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_prod,
    output logic        o_done
);

    logic [63:0] r_a, r_b, r_acc;
    logic [1:0]  r_step;
    logic        r_busy, r_done;
    logic [31:0] ma, mb;
    logic [63:0] pp;

    always_comb begin
        ma = (r_step == 2'd2) ? r_a[63:32] : r_a[31:0];
        mb = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
        pp = ma * mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (r_step == 2'd0) begin
                r_acc <= pp;
            end else begin
                r_acc <= r_acc + {pp[31:0], 32'd0};
            end
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

### rtl/core/brs_div.sv
// restoring remainder, one quotient bit per cycle
module brs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic [63:0] o_rem,
    output logic        o_done
);

    logic [63:0] r_rem, r_q, r_d;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] t;
    logic [64:0] diff;

    always_comb begin
        t    = {r_rem, r_q[63]};
        diff = t - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 64'd0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], 1'b0};
            if (!diff[64]) begin
                r_rem <= diff[63:0];
            end else begin
                r_rem <= t[63:0];
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### rtl/core/brs_datapath.sv
module brs_datapath #(
    parameter int NUM_BINS     = 16,
    parameter int MAX_DEPTH    = 256,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_func,
    input  logic [3:0]        i_bin,
    input  logic [7:0]        i_slot,
    input  logic [63:0]       i_photon,
    input  brs_pkg::t_dp_cmd  i_cmd,
    output brs_pkg::t_dp_stat o_stat,
    output logic [2:0]        o_status,
    output logic              o_stored,
    output logic [7:0]        o_slot_used,
    output logic [8:0]        o_held_count,
    output logic [63:0]       o_offered_count,
    output logic [63:0]       o_donor
);

    localparam int BW        = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int FW        = $clog2(MAX_DEPTH + 1);
    localparam int RES_DEPTH = NUM_BINS * MAX_DEPTH;
    localparam int RAW       = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int TW_DEPTH  = NUM_BINS * brs_pkg::MT_N;
    localparam int TAW       = $clog2(TW_DEPTH);
    localparam int IW        = brs_pkg::IDXW;

    // configuration
    logic [63:0] r_seed;
    logic [8:0]  r_depth;
    logic        r_frozen;

    // per-bin control state
    logic [FW-1:0] r_fill  [NUM_BINS];
    logic [63:0]   r_seen  [NUM_BINS];
    logic [IW-1:0] r_twidx [NUM_BINS];

    // item and work registers
    logic                    r_func, r_bin_ok;
    logic [BW-1:0]           r_bin;
    logic [7:0]              r_slot;
    logic [PAYLOAD_BITS-1:0] r_photon;
    logic [63:0]             r_x, r_cur, r_u, r_limit, r_j;
    logic                    r_lcg;
    logic [IW-1:0]           r_widx;
    brs_pkg::t_status        r_status;
    logic                    r_stored;
    logic [7:0]              r_used;

    // result registers
    logic [2:0]  r_o_status;
    logic        r_o_stored;
    logic [7:0]  r_o_used;
    logic [8:0]  r_o_held;
    logic [63:0] r_o_offered, r_o_donor;

    // memories
    logic [PAYLOAD_BITS-1:0] res_mem [RES_DEPTH];
    logic [63:0]             tw_mem  [TW_DEPTH];
    logic [PAYLOAD_BITS-1:0] r_res_rd;
    logic [63:0]             r_tw_rda, r_tw_rdb;

    brs_pkg::t_op     op;
    logic [FW-1:0]    fill_cur, dnow;
    logic [63:0]      seen_cur;
    logic [IW-1:0]    twidx_cur, nxt1, nxtm;
    logic             fill_lt_d, ok_offer, j_lt_d, n_le1;
    brs_pkg::t_status chk_code;
    logic             mul_start, div_start, mul_done, div_done;
    logic [63:0]      mul_a, mul_b, mul_prod, div_num, div_rem;
    logic [RAW-1:0]   res_base, res_raddr, res_waddr;
    logic             res_we;
    logic [TAW-1:0]   tw_base, tw_raddra, tw_raddrb, tw_waddr;
    logic             tw_we;
    logic [63:0]      tw_wdata, mt_x, mt_xa;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] y;
        y = w;
        y = y ^ ((y >> 29) & brs_pkg::TMP_B);
        y = y ^ ((y << 17) & brs_pkg::TMP_C);
        y = y ^ ((y << 37) & brs_pkg::TMP_D);
        y = y ^ (y >> 43);
        return y;
    endfunction

    assign op = i_cmd.op;

    always_comb begin
        fill_cur  = r_fill[r_bin];
        seen_cur  = r_seen[r_bin];
        twidx_cur = r_twidx[r_bin];
        if (r_depth == 9'd0) begin
            dnow = FW'(1);
        end else if (32'(r_depth) > MAX_DEPTH) begin
            dnow = FW'(MAX_DEPTH);
        end else begin
            dnow = FW'(r_depth);
        end
        fill_lt_d = fill_cur < dnow;
        j_lt_d    = r_j < 64'(dnow);
        n_le1     = seen_cur <= 64'd1;

        // offers and reads both check the frozen state before the bin; reads also check the slot
        if (r_func == brs_pkg::FUNC_OFFER) begin
            if (r_frozen) begin
                chk_code = brs_pkg::ST_FROZEN;
            end else if (!r_bin_ok) begin
                chk_code = brs_pkg::ST_BAD_BIN;
            end else begin
                chk_code = brs_pkg::ST_OK;
            end
        end else begin
            if (!r_frozen) begin
                chk_code = brs_pkg::ST_NOT_FROZEN;
            end else if (!r_bin_ok) begin
                chk_code = brs_pkg::ST_BAD_BIN;
            end else if (32'(r_slot) >= 32'(fill_cur)) begin
                chk_code = brs_pkg::ST_EMPTY;
            end else begin
                chk_code = brs_pkg::ST_OK;
            end
        end
        ok_offer = (r_func == brs_pkg::FUNC_OFFER) && (chk_code == brs_pkg::ST_OK);
    end

    // shared multiplier and divider operands
    always_comb begin
        mul_start = (op == brs_pkg::OP_MUL1) || (op == brs_pkg::OP_MUL2) ||
                    (op == brs_pkg::OP_LCG);
        case (op)
            brs_pkg::OP_MUL1: begin
                mul_a = r_x ^ (r_x >> brs_pkg::MIX_SH1);
                mul_b = brs_pkg::MIX_MUL1;
            end
            brs_pkg::OP_MUL2: begin
                mul_a = r_x ^ (r_x >> brs_pkg::MIX_SH2);
                mul_b = brs_pkg::MIX_MUL2;
            end
            default: begin
                mul_a = r_x ^ (r_x >> brs_pkg::LCG_SH);
                mul_b = brs_pkg::LCG_MUL;
            end
        endcase
        div_start = ((op == brs_pkg::OP_DRAW) && !n_le1) || (op == brs_pkg::OP_JSTART);
        div_num   = (op == brs_pkg::OP_JSTART) ? r_u : (64'd0 - seen_cur);
    end

    brs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    brs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (seen_cur),
        .o_rem      (div_rem),
        .o_done     (div_done)
    );

    // addresses
    always_comb begin
        res_base  = RAW'(32'(r_bin) * MAX_DEPTH);
        res_raddr = res_base + RAW'(r_slot);
        res_waddr = res_base + ((op == brs_pkg::OP_CHECK) ? RAW'(fill_cur) : RAW'(r_j));
        res_we    = ((op == brs_pkg::OP_CHECK) && ok_offer && fill_lt_d) ||
                    ((op == brs_pkg::OP_JUSE) && j_lt_d);

        nxt1 = (r_widx == IW'(brs_pkg::MT_N - 1)) ? IW'(0) : r_widx + IW'(1);
        nxtm = (r_widx < IW'(brs_pkg::MT_N - brs_pkg::MT_M)) ?
               r_widx + IW'(brs_pkg::MT_M) : r_widx - IW'(brs_pkg::MT_N - brs_pkg::MT_M);

        tw_base = TAW'(32'(r_bin) * brs_pkg::MT_N);
        case (op)
            brs_pkg::OP_GRD: tw_raddra = tw_base + TAW'(twidx_cur);
            brs_pkg::OP_RGR: tw_raddra = tw_base + TAW'(nxt1);
            default:         tw_raddra = tw_base;
        endcase
        tw_raddrb = tw_base + TAW'(nxtm);

        mt_x  = (r_cur & brs_pkg::MT_UPPER) | (r_tw_rda & brs_pkg::MT_LOWER);
        mt_xa = (mt_x >> 1) ^ (mt_x[0] ? brs_pkg::MT_MATRIX : 64'd0);

        tw_we    = (op == brs_pkg::OP_SD_WR0) || (op == brs_pkg::OP_SD_WR) ||
                   (op == brs_pkg::OP_RGW);
        tw_waddr = tw_base + ((op == brs_pkg::OP_SD_WR0) ? TAW'(0) : TAW'(r_widx));
        tw_wdata = (op == brs_pkg::OP_RGW) ? (r_tw_rdb ^ mt_xa) : r_x;
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[res_waddr] <= r_photon;
        end
        r_res_rd <= res_mem[res_raddr];
        if (tw_we) begin
            tw_mem[tw_waddr] <= tw_wdata;
        end
        r_tw_rda <= tw_mem[tw_raddra];
        r_tw_rdb <= tw_mem[tw_raddrb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= 64'd0;
            r_depth  <= 9'd200;
            r_frozen <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brs_pkg::REG_SEED:   r_seed   <= i_cfg_data;
                brs_pkg::REG_DEPTH:  r_depth  <= i_cfg_data[8:0];
                brs_pkg::REG_FROZEN: r_frozen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                r_fill[b]  <= '0;
                r_seen[b]  <= 64'd0;
                r_twidx[b] <= IW'(brs_pkg::MT_N);
            end
        end else begin
            case (op)
                brs_pkg::OP_SD_CLEAR: begin
                    for (int b = 0; b < NUM_BINS; b++) begin
                        r_fill[b] <= '0;
                        r_seen[b] <= 64'd0;
                    end
                end
                brs_pkg::OP_SD_NEXT: r_twidx[r_bin] <= IW'(brs_pkg::MT_N);
                brs_pkg::OP_CHECK: begin
                    if (ok_offer) begin
                        if (seen_cur != '1) begin
                            r_seen[r_bin] <= seen_cur + 64'd1;
                        end
                        if (fill_lt_d) begin
                            r_fill[r_bin] <= fill_cur + FW'(1);
                        end
                    end
                end
                brs_pkg::OP_GUSE: r_twidx[r_bin] <= twidx_cur + IW'(1);
                brs_pkg::OP_RGW: begin
                    if (r_widx == IW'(brs_pkg::MT_N - 1)) begin
                        r_twidx[r_bin] <= IW'(0);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_bin    <= BW'(i_bin);
            r_bin_ok <= 32'(i_bin) < NUM_BINS;
            r_slot   <= i_slot;
            r_photon <= PAYLOAD_BITS'(i_photon);
        end
        case (op)
            brs_pkg::OP_SD_CLEAR:    r_bin <= '0;
            brs_pkg::OP_SD_LOADBIN:  r_x   <= 64'(r_bin) + brs_pkg::GOLDEN;
            brs_pkg::OP_SD_LOADSEED: r_x   <= (r_seed ^ r_x) + brs_pkg::GOLDEN;
            brs_pkg::OP_MUL1:        r_lcg <= 1'b0;
            brs_pkg::OP_MUL2:        r_lcg <= 1'b0;
            brs_pkg::OP_MULWAIT: begin
                if (mul_done) begin
                    r_x <= mul_prod + (r_lcg ? 64'(r_widx) : 64'd0);
                end
            end
            brs_pkg::OP_FIN:    r_x <= r_x ^ (r_x >> brs_pkg::MIX_SH3);
            brs_pkg::OP_SD_WR0: r_widx <= IW'(0);
            brs_pkg::OP_LCG: begin
                r_lcg  <= 1'b1;
                r_widx <= r_widx + IW'(1);
            end
            brs_pkg::OP_SD_NEXT: r_bin <= r_bin + BW'(1);
            brs_pkg::OP_CHECK: begin
                r_status <= chk_code;
                r_stored <= ok_offer && fill_lt_d;
                if (ok_offer && fill_lt_d) begin
                    r_used <= 8'(fill_cur);
                end else begin
                    r_used <= ((r_func == brs_pkg::FUNC_READ) &&
                               (chk_code == brs_pkg::ST_OK)) ? r_slot : 8'd0;
                end
            end
            brs_pkg::OP_DRAW: begin
                if (n_le1) begin
                    r_j <= 64'd0;
                end
            end
            brs_pkg::OP_LIMWAIT: begin
                if (div_done) begin
                    r_limit <= div_rem;
                end
            end
            brs_pkg::OP_GUSE: r_u <= temper(r_tw_rda);
            brs_pkg::OP_JWAIT: begin
                if (div_done) begin
                    r_j <= div_rem;
                end
            end
            brs_pkg::OP_JUSE: begin
                if (j_lt_d) begin
                    r_stored <= 1'b1;
                    r_used   <= 8'(r_j);
                end
            end
            brs_pkg::OP_RG0: r_widx <= IW'(0);
            brs_pkg::OP_RG1: r_cur  <= r_tw_rda;
            brs_pkg::OP_RGW: begin
                r_cur  <= r_tw_rda;
                r_widx <= nxt1;
            end
            default: ;
        endcase
        if (i_cmd.res_load) begin
            r_o_status  <= r_status;
            r_o_stored  <= r_stored;
            r_o_used    <= r_used;
            r_o_held    <= r_bin_ok ? 9'(fill_cur) : 9'd0;
            r_o_offered <= r_bin_ok ? seen_cur : 64'd0;
            r_o_donor   <= ((r_func == brs_pkg::FUNC_READ) && (r_status == brs_pkg::ST_OK)) ?
                           64'(r_res_rd) : 64'd0;
        end
    end

    always_comb begin
        o_stat.seed_wr   = i_cfg_we && (i_cfg_index == brs_pkg::REG_SEED);
        o_stat.mul_done  = mul_done;
        o_stat.div_done  = div_done;
        o_stat.need_draw = ok_offer && !fill_lt_d;
        o_stat.n_le1     = n_le1;
        o_stat.tw_full   = twidx_cur >= IW'(brs_pkg::MT_N);
        o_stat.u_ok      = r_u >= r_limit;
        o_stat.widx_last = r_widx == IW'(brs_pkg::MT_N - 1);
        o_stat.bin_last  = 32'(r_bin) == NUM_BINS - 1;
    end

    assign o_status        = r_o_status;
    assign o_stored        = r_o_stored;
    assign o_slot_used     = r_o_used;
    assign o_held_count    = r_o_held;
    assign o_offered_count = r_o_offered;
    assign o_donor         = r_o_donor;

endmodule

### rtl/core/brs_ctrl.sv
module brs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  brs_pkg::t_dp_stat i_stat,
    output brs_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_SD_START, S_SD_BIN, S_SD_M1, S_SD_W1, S_SD_M2, S_SD_W2, S_SD_FIN,
        S_SD_SEED, S_SD_WR0, S_SD_LCG, S_SD_WL, S_SD_WR, S_SD_NEXT,
        S_IDLE, S_CHK, S_DRAW, S_LIMW, S_GEN, S_GRD, S_GUSE, S_GCMP,
        S_JST, S_JW, S_JUSE, S_RG0, S_RG1, S_RGR, S_RGW, S_DONE
    } t_state;

    t_state r_state;
    logic   r_pass;
    logic   r_ovalid;
    logic   done_go;

    assign done_go     = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.res_load = (r_state == S_DONE) && done_go;
        case (r_state)
            S_SD_START: o_cmd.op = brs_pkg::OP_SD_CLEAR;
            S_SD_BIN:   o_cmd.op = brs_pkg::OP_SD_LOADBIN;
            S_SD_M1:    o_cmd.op = brs_pkg::OP_MUL1;
            S_SD_M2:    o_cmd.op = brs_pkg::OP_MUL2;
            S_SD_W1,
            S_SD_W2,
            S_SD_WL:    o_cmd.op = brs_pkg::OP_MULWAIT;
            S_SD_FIN:   o_cmd.op = brs_pkg::OP_FIN;
            S_SD_SEED:  o_cmd.op = brs_pkg::OP_SD_LOADSEED;
            S_SD_WR0:   o_cmd.op = brs_pkg::OP_SD_WR0;
            S_SD_LCG:   o_cmd.op = brs_pkg::OP_LCG;
            S_SD_WR:    o_cmd.op = brs_pkg::OP_SD_WR;
            S_SD_NEXT:  o_cmd.op = brs_pkg::OP_SD_NEXT;
            S_CHK:      o_cmd.op = brs_pkg::OP_CHECK;
            S_DRAW:     o_cmd.op = brs_pkg::OP_DRAW;
            S_LIMW:     o_cmd.op = brs_pkg::OP_LIMWAIT;
            S_GRD:      o_cmd.op = brs_pkg::OP_GRD;
            S_GUSE:     o_cmd.op = brs_pkg::OP_GUSE;
            S_JST:      o_cmd.op = brs_pkg::OP_JSTART;
            S_JW:       o_cmd.op = brs_pkg::OP_JWAIT;
            S_JUSE:     o_cmd.op = brs_pkg::OP_JUSE;
            S_RG0:      o_cmd.op = brs_pkg::OP_RG0;
            S_RG1:      o_cmd.op = brs_pkg::OP_RG1;
            S_RGR:      o_cmd.op = brs_pkg::OP_RGR;
            S_RGW:      o_cmd.op = brs_pkg::OP_RGW;
            default:    o_cmd.op = brs_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SD_START;
            r_pass   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_stat.seed_wr) begin
                // a new seed restarts the whole seeding pass
                r_state <= S_SD_START;
            end else begin
                case (r_state)
                    S_SD_START: r_state <= S_SD_BIN;
                    S_SD_BIN: begin
                        r_pass  <= 1'b0;
                        r_state <= S_SD_M1;
                    end
                    S_SD_M1: r_state <= S_SD_W1;
                    S_SD_W1: if (i_stat.mul_done) r_state <= S_SD_M2;
                    S_SD_M2: r_state <= S_SD_W2;
                    S_SD_W2: if (i_stat.mul_done) r_state <= S_SD_FIN;
                    S_SD_FIN: r_state <= r_pass ? S_SD_WR0 : S_SD_SEED;
                    S_SD_SEED: begin
                        r_pass  <= 1'b1;
                        r_state <= S_SD_M1;
                    end
                    S_SD_WR0: r_state <= S_SD_LCG;
                    S_SD_LCG: r_state <= S_SD_WL;
                    S_SD_WL:  if (i_stat.mul_done) r_state <= S_SD_WR;
                    S_SD_WR:  r_state <= i_stat.widx_last ? S_SD_NEXT : S_SD_LCG;
                    S_SD_NEXT: r_state <= i_stat.bin_last ? S_IDLE : S_SD_BIN;
                    S_IDLE: if (i_in_valid) r_state <= S_CHK;
                    S_CHK:  r_state <= i_stat.need_draw ? S_DRAW : S_DONE;
                    S_DRAW: r_state <= i_stat.n_le1 ? S_JUSE : S_LIMW;
                    S_LIMW: if (i_stat.div_done) r_state <= S_GEN;
                    S_GEN:  r_state <= i_stat.tw_full ? S_RG0 : S_GRD;
                    S_GRD:  r_state <= S_GUSE;
                    S_GUSE: r_state <= S_GCMP;
                    S_GCMP: r_state <= i_stat.u_ok ? S_JST : S_GEN;
                    S_JST:  r_state <= S_JW;
                    S_JW:   if (i_stat.div_done) r_state <= S_JUSE;
                    S_JUSE: r_state <= S_DONE;
                    S_RG0:  r_state <= S_RG1;
                    S_RG1:  r_state <= S_RGR;
                    S_RGR:  r_state <= S_RGW;
                    S_RGW:  r_state <= i_stat.widx_last ? S_GEN : S_RGR;
                    S_DONE: if (done_go) r_state <= S_IDLE;
                    default: r_state <= S_SD_START;
                endcase
            end
        end
    end

endmodule

### rtl/core/binned_reservoir_sampler_top.sv
// reads, errors and offers to a bin not yet full go from the check state to the done state
// offers to a full bin also take two remainders in the serial divider and one or more twister
//   draws, plus a twister regeneration every 312 draws
// throughput: one item at a time; the next transfer is taken once the result is registered
// reset (synchronous, active low) and seed writes run a seeding pass over all NUM_BINS bins,
//   bound by the shared multiplier; no item is taken meanwhile
module binned_reservoir_sampler_top #(
    parameter int NUM_BINS     = 16,
    parameter int MAX_DEPTH    = 256,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [79:0]  i_s_axis_tdata,  // bin[3:0], slot[11:4], photon[75:12], zero pad
    input  logic [0:0]   i_s_axis_tuser,  // func[0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [151:0] o_m_axis_tdata,  // slot_used[7:0], held_count[16:8],
                                          // offered_count[80:17], donor[144:81], zero pad
    output logic [3:0]   o_m_axis_tuser,  // status[2:0], stored[3]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    brs_pkg::t_dp_cmd  cmd;
    brs_pkg::t_dp_stat stat;
    logic [2:0]        status;
    logic              stored;
    logic [7:0]        slot_used;
    logic [8:0]        held_count;
    logic [63:0]       offered_count, donor;

    assign o_cfg_ready = 1'b1;

    brs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    brs_datapath #(
        .NUM_BINS     (NUM_BINS),
        .MAX_DEPTH    (MAX_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_s_axis_tuser[0]),
        .i_bin           (i_s_axis_tdata[3:0]),
        .i_slot          (i_s_axis_tdata[11:4]),
        .i_photon        (i_s_axis_tdata[75:12]),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (status),
        .o_stored        (stored),
        .o_slot_used     (slot_used),
        .o_held_count    (held_count),
        .o_offered_count (offered_count),
        .o_donor         (donor)
    );

    assign o_m_axis_tdata = {7'd0, donor, offered_count, held_count, slot_used};
    assign o_m_axis_tuser = {stored, status};

endmodule
